[src/stack_machine_executor_top_defines.svh]
// Assertion macros for the stack machine executor checker.
// Used only by the bound checker; no other dependencies.
`ifndef STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack machine check failed");

// Next-cycle implication, disabled while reset is asserted
`define SME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack machine check failed");

`endif

[src/sme_pkg.sv]
// Shared types, codes and constants of the stack machine executor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sme_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int KIND_W          = 4;
    localparam int LIMIT_W         = 31;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1000000000;

    // Instruction kinds
    localparam logic [KIND_W-1:0] KIND_START  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NUM    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_INV    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DUP    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SWP    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_ADD    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SUB    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MUL    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DIV    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_MOD    = 4'd10;
    localparam logic [KIND_W-1:0] KIND_FINISH = 4'd11;

    // Result status codes
    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_ERR  = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;

    // Register index of the limit
    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_START,
        DP_PUSH_IMM,
        DP_DUP,
        DP_READ2,
        DP_POP,
        DP_SWP,
        DP_INV_CALC,
        DP_ALU_CALC,
        DP_DIV_START,
        DP_DIV_TAKE,
        DP_COMMIT_UNARY,
        DP_COMMIT_BIN,
        DP_SET_ERR,
        DP_OUT
    } t_dp_op;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_QUO,
        ALU_REM
    } t_alu_op;

    typedef struct packed {
        t_dp_op  op;
        t_alu_op alu;
        logic    fin;
    } t_dp_cmd;

    typedef struct packed {
        logic depth_zero;
        logic depth_lt2;
        logic depth_full;
        logic err;
        logic tos_zero;
        logic div_done;
    } t_dp_stat;

endpackage

[src/sme_div.sv]
// Iterative 32-bit signed divider, one quotient bit per cycle, truncating.
// Depends on sme_pkg for the data width.
`timescale 1ns / 1ps

module sme_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [sme_pkg::DATA_W-1:0]  i_dividend,
    input  logic signed [sme_pkg::DATA_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic signed [sme_pkg::DATA_W:0]    o_quo,
    output logic signed [sme_pkg::DATA_W-1:0]  o_rem
);
    localparam int W  = sme_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic          r_neg_q;
    logic          r_neg_r;

    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    // Trial subtract of the divisor magnitude
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_b};

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes and restoring shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= i_dividend[W-1] ? W'(-i_dividend) : i_dividend;
            r_b     <= i_divisor[W-1] ? W'(-i_divisor) : i_divisor;
            r_rem   <= '0;
            r_neg_q <= i_dividend[W-1] ^ i_divisor[W-1];
            r_neg_r <= i_dividend[W-1];
        end else if (r_busy) begin
            r_rem <= w_diff[W] ? w_shift[W-1:0] : w_diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~w_diff[W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg_q ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_rem  = r_neg_r ? -$signed(r_rem) : $signed(r_rem);

endmodule

[src/sme_dp.sv]
// Datapath: stack memory, cached top of stack, ALU, limit check, result register.
// Depends on sme_pkg and sme_div.
`timescale 1ns / 1ps

module sme_dp #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int DW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sme_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [sme_pkg::DATA_W-1:0]  i_operand,
    input  logic [sme_pkg::LIMIT_W-1:0]        i_limit,
    output sme_pkg::t_dp_stat                  o_stat,
    output logic [1:0]                         o_status,
    output logic signed [sme_pkg::DATA_W-1:0]  o_top,
    output logic [DW-1:0]                      o_depth
);
    localparam int W = sme_pkg::DATA_W;

    // Stack entries below the top; the top itself lives in r_tos
    logic [W-1:0]        r_mem [STACK_DEPTH];
    logic signed [W-1:0] r_rdata;
    logic signed [W-1:0] r_tos;
    logic signed [W-1:0] r_opnd;
    logic [DW-1:0]       r_depth;
    logic                r_err;
    logic signed [2*W-1:0] r_res;
    logic [1:0]          r_status;
    logic signed [W-1:0] r_top;
    logic [DW-1:0]       r_depth_out;

    logic [DW-1:0]       w_depth_m1;
    logic [DW-1:0]       w_depth_m2;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic signed [2*W-1:0] w_prod;
    logic signed [2*W-1:0] w_lim;
    logic signed [2*W-1:0] w_alu;
    logic                w_over;
    logic                w_div_done;
    logic signed [W:0]   w_quo;
    logic signed [W-1:0] w_rem;

    assign w_depth_m1 = r_depth - 1'b1;
    assign w_depth_m2 = r_depth - 2'd2;

    // Memory port control
    assign w_we    = (i_cmd.op == sme_pkg::DP_PUSH_IMM && r_depth != '0)
                   || i_cmd.op == sme_pkg::DP_DUP || i_cmd.op == sme_pkg::DP_SWP;
    assign w_waddr = (i_cmd.op == sme_pkg::DP_SWP) ? w_depth_m2[AW-1:0] : w_depth_m1[AW-1:0];
    assign w_raddr = w_depth_m2[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_tos;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Arithmetic on second (s) and top (t)
    assign w_prod = r_rdata * r_tos;

    always_comb begin
        unique case (i_cmd.alu)
            sme_pkg::ALU_ADD: w_alu = 64'(r_rdata) + 64'(r_tos);
            sme_pkg::ALU_SUB: w_alu = 64'(r_rdata) - 64'(r_tos);
            default:          w_alu = w_prod;
        endcase
    end

    sme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == sme_pkg::DP_DIV_START),
        .i_dividend (r_rdata),
        .i_divisor  (r_tos),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Magnitude check of the computed result
    assign w_lim  = $signed({{(2*W-sme_pkg::LIMIT_W){1'b0}}, i_limit});
    assign w_over = (r_res > w_lim) || (r_res < -w_lim);

    // Control state: depth and error latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                sme_pkg::DP_START: begin
                    r_depth <= DW'(1);
                    r_err   <= 1'b0;
                end
                sme_pkg::DP_PUSH_IMM, sme_pkg::DP_DUP: r_depth <= r_depth + 1'b1;
                sme_pkg::DP_POP:   r_depth <= w_depth_m1;
                sme_pkg::DP_SET_ERR: r_err <= 1'b1;
                sme_pkg::DP_COMMIT_UNARY: begin
                    // an out-of-range negation still drops the old top
                    if (w_over) begin
                        r_err   <= 1'b1;
                        r_depth <= w_depth_m1;
                    end
                end
                sme_pkg::DP_COMMIT_BIN: begin
                    if (w_over) r_err <= 1'b1;
                    else        r_depth <= w_depth_m1;
                end
                default: ;
            endcase
        end
    end

    // Payload: top of stack, result, output register
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sme_pkg::DP_CAPTURE:  r_opnd <= i_operand;
            sme_pkg::DP_START,
            sme_pkg::DP_PUSH_IMM: r_tos <= r_opnd;
            sme_pkg::DP_POP,
            sme_pkg::DP_SWP:      r_tos <= r_rdata;
            sme_pkg::DP_INV_CALC: r_res <= -64'(r_tos);
            sme_pkg::DP_ALU_CALC: r_res <= w_alu;
            sme_pkg::DP_DIV_TAKE: r_res <= (i_cmd.alu == sme_pkg::ALU_QUO) ? 64'(w_quo)
                                                                          : 64'(w_rem);
            sme_pkg::DP_COMMIT_UNARY,
            sme_pkg::DP_COMMIT_BIN: begin
                if (!w_over) r_tos <= r_res[W-1:0];
            end
            sme_pkg::DP_OUT: begin
                r_depth_out <= r_depth;
                if (i_cmd.fin) begin
                    if (!r_err && r_depth == DW'(1)) begin
                        r_status <= sme_pkg::STAT_DONE;
                        r_top    <= r_tos;
                    end else begin
                        r_status <= sme_pkg::STAT_ERR;
                        r_top    <= '0;
                    end
                end else if (r_err) begin
                    r_status <= sme_pkg::STAT_ERR;
                    r_top    <= '0;
                end else begin
                    r_status <= sme_pkg::STAT_RUN;
                    r_top    <= (r_depth != '0) ? r_tos : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.depth_lt2  = (r_depth < DW'(2));
    assign o_stat.depth_full = (r_depth == DW'(STACK_DEPTH));
    assign o_stat.err        = r_err;
    assign o_stat.tos_zero   = (r_tos == '0);
    assign o_stat.div_done   = w_div_done;

    assign o_status = r_status;
    assign o_top    = r_top;
    assign o_depth  = r_depth_out;

endmodule

[src/sme_ctrl.sv]
// Controller: sequences one instruction at a time over the datapath.
// Depends on sme_pkg for kinds, commands and status.
`timescale 1ns / 1ps

module sme_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sme_pkg::KIND_W-1:0]     i_kind,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  sme_pkg::t_dp_stat              i_stat,
    output sme_pkg::t_dp_cmd               o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_EXEC,
        S_DIV,
        S_CHK,
        S_OUT
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [sme_pkg::KIND_W-1:0] r_kind;
    logic                       r_out_valid;
    logic                       w_accept;
    logic                       w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // ALU selection from the instruction kind
    always_comb begin
        priority case (r_kind)
            sme_pkg::KIND_ADD: o_cmd.alu = sme_pkg::ALU_ADD;
            sme_pkg::KIND_SUB: o_cmd.alu = sme_pkg::ALU_SUB;
            sme_pkg::KIND_MUL: o_cmd.alu = sme_pkg::ALU_MUL;
            sme_pkg::KIND_DIV: o_cmd.alu = sme_pkg::ALU_QUO;
            default:           o_cmd.alu = sme_pkg::ALU_REM;
        endcase
    end
    assign o_cmd.fin = (r_kind == sme_pkg::KIND_FINISH);

    // Next state and datapath command
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = sme_pkg::DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.op = sme_pkg::DP_CAPTURE;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                priority if (r_kind == sme_pkg::KIND_START) begin
                    o_cmd.op = sme_pkg::DP_START;
                end else if (r_kind > sme_pkg::KIND_MOD || i_stat.err) begin
                    o_cmd.op = sme_pkg::DP_NOP;
                end else if (r_kind == sme_pkg::KIND_NUM) begin
                    o_cmd.op = i_stat.depth_full ? sme_pkg::DP_SET_ERR : sme_pkg::DP_PUSH_IMM;
                end else if (r_kind == sme_pkg::KIND_POP) begin
                    o_cmd.op = i_stat.depth_zero ? sme_pkg::DP_SET_ERR : sme_pkg::DP_READ2;
                    n_state  = i_stat.depth_zero ? S_OUT : S_EXEC;
                end else if (r_kind == sme_pkg::KIND_INV) begin
                    o_cmd.op = i_stat.depth_zero ? sme_pkg::DP_SET_ERR : sme_pkg::DP_INV_CALC;
                    n_state  = i_stat.depth_zero ? S_OUT : S_CHK;
                end else if (r_kind == sme_pkg::KIND_DUP) begin
                    o_cmd.op = (i_stat.depth_zero || i_stat.depth_full) ? sme_pkg::DP_SET_ERR
                                                                        : sme_pkg::DP_DUP;
                end else begin
                    // swap and two-operand arithmetic
                    o_cmd.op = i_stat.depth_lt2 ? sme_pkg::DP_SET_ERR : sme_pkg::DP_READ2;
                    n_state  = i_stat.depth_lt2 ? S_OUT : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_CHK;
                priority if (r_kind == sme_pkg::KIND_POP) begin
                    o_cmd.op = sme_pkg::DP_POP;
                    n_state  = S_OUT;
                end else if (r_kind == sme_pkg::KIND_SWP) begin
                    o_cmd.op = sme_pkg::DP_SWP;
                    n_state  = S_OUT;
                end else if (r_kind == sme_pkg::KIND_DIV || r_kind == sme_pkg::KIND_MOD) begin
                    o_cmd.op = i_stat.tos_zero ? sme_pkg::DP_SET_ERR : sme_pkg::DP_DIV_START;
                    n_state  = i_stat.tos_zero ? S_OUT : S_DIV;
                end else begin
                    o_cmd.op = sme_pkg::DP_ALU_CALC;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.op = sme_pkg::DP_DIV_TAKE;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.op = (r_kind == sme_pkg::KIND_INV) ? sme_pkg::DP_COMMIT_UNARY
                                                         : sme_pkg::DP_COMMIT_BIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.op = sme_pkg::DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, captured kind and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kind      <= sme_pkg::KIND_START;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_kind <= i_kind;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/stack_machine_executor_top.sv]
// Stack machine executor: one instruction in work at a time, one result each. States:
// DEC, OUT for start/num/dup/finish/unused kinds/decode errors; DEC, EXEC, OUT for pop,
// swap, divide by zero; DEC, CHK, OUT for negate; DEC, EXEC, CHK, OUT for add/sub/mul;
// DEC, EXEC, DIV (until divider done), CHK, OUT for div/mod. OUT waits for a free output
// register; the next request is taken once it holds the result. Synchronous active-low
// reset empties the stack, clears the error latch, loads the limit with 1000000000.
`timescale 1ns / 1ps

module stack_machine_executor_top #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    localparam int DW    = $clog2(STACK_DEPTH + 1),
    localparam int IN_W  = ((sme_pkg::KIND_W + sme_pkg::DATA_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 + sme_pkg::DATA_W + DW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // kind [3:0], operand [35:4]
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    // status [1:0], top_value [33:2], stack_depth [33+DW:34]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int W = sme_pkg::DATA_W;

    logic [sme_pkg::LIMIT_W-1:0] r_limit;
    sme_pkg::t_dp_cmd            w_cmd;
    sme_pkg::t_dp_stat           w_stat;
    logic [1:0]                  w_status;
    logic signed [W-1:0]         w_top;
    logic [DW-1:0]               w_depth;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sme_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == sme_pkg::REG_LIMIT) begin
            r_limit <= pwdata[sme_pkg::LIMIT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == sme_pkg::REG_LIMIT) ? {1'b0, r_limit} : '0;

    sme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tdata[sme_pkg::KIND_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sme_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_operand (s_axis_tdata[sme_pkg::KIND_W +: W]),
        .i_limit   (r_limit),
        .o_stat    (w_stat),
        .o_status  (w_status),
        .o_top     (w_top),
        .o_depth   (w_depth)
    );

    assign m_axis_tdata = OUT_W'({w_depth, w_top, w_status});

endmodule

[src/sme_checker.sv]
// Port-level checker for the stack machine executor, bound to the top level.
// Depends on the assertion macro header and sme_pkg.
`timescale 1ns / 1ps
`include "stack_machine_executor_top_defines.svh"

module sme_checker #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    localparam int DW    = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W = ((2 + sme_pkg::DATA_W + DW + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             pready
);
    logic [1:0]    w_status;
    logic [31:0]   w_top;
    logic [DW-1:0] w_depth;

    assign w_status = m_axis_tdata[1:0];
    assign w_top    = m_axis_tdata[33:2];
    assign w_depth  = m_axis_tdata[34 +: DW];

    // a stalled result holds
    `SME_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // status code three never leaves
    `SME_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, w_status != 2'd3)
    // a successful finish leaves exactly one value
    `SME_ASSERT_IMP(a_done_one, i_clk, i_rst_n, m_axis_tvalid && w_status == sme_pkg::STAT_DONE, w_depth == DW'(1))
    // an error result carries a zero top
    `SME_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && w_status == sme_pkg::STAT_ERR, w_top == '0)
    // depth stays within the stack, config port never stalls
    `SME_ASSERT_IMP(a_depth_max, i_clk, i_rst_n, m_axis_tvalid, w_depth <= DW'(STACK_DEPTH) && pready)

endmodule

bind stack_machine_executor_top sme_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
